// ----- hdl/rgb_share_window_classifier_assert.svh -----
// Assertion macros shared by the classifier modules.
`ifndef RGB_SHARE_WINDOW_CLASSIFIER_ASSERT_SVH
`define RGB_SHARE_WINDOW_CLASSIFIER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define RSW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a condition in the same cycle.
`define RSW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition in one cycle implies a condition in the next cycle.
`define RSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rsw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsw_pkg;

    localparam int RGB_W       = 16;
    localparam int SUM_W       = 18;
    localparam int NUM_W       = 23;
    localparam int QBITS       = 7;
    localparam int DIV_W       = SUM_W + QBITS - 1;
    localparam int WIN_W       = 48;
    localparam int MAX_CLASSES = 8;
    localparam int CLASS_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 8;

    localparam logic [NUM_W-1:0]   SHARE_SCALE = NUM_W'(100);
    localparam logic [CLASS_W-1:0] CLASS_NONE  = '0;

    typedef logic [WIN_W-1:0] t_window;

    localparam t_window WINDOW_RESET [MAX_CLASSES] = '{
        48'd81690446531855, 48'd39746318046230, 48'd33123360579875,
        48'd55199425106195, 48'd52991778231575, 48'd65133549719570,
        48'd36434847734300, 48'd47472812627480
    };

    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] sum;
        logic [NUM_W-1:0] rem_r;
        logic [NUM_W-1:0] rem_g;
        logic [NUM_W-1:0] rem_b;
        logic [QBITS-1:0] q_r;
        logic [QBITS-1:0] q_g;
        logic [QBITS-1:0] q_b;
    } t_div_bus;

    function automatic logic in_band(input logic [QBITS-1:0] share, input logic [7:0] lo,
                                     input logic [7:0] hi);
        logic [7:0] s;
        s = 8'(share);
        return (lo <= s) && (s <= hi);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rsw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_share_window_classifier_assert.svh"

module rsw_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [rsw_pkg::RGB_W-1:0] i_red,
    input  wire logic [rsw_pkg::RGB_W-1:0] i_green,
    input  wire logic [rsw_pkg::RGB_W-1:0] i_blue,
    input  wire logic                    i_request,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output rsw_pkg::t_div_bus            o_bus
);
    import rsw_pkg::*;

    logic     r_valid;
    t_div_bus r_bus;
    t_div_bus n_bus;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_bus   = r_bus;

    always_comb begin
        n_bus       = '0;
        n_bus.sum   = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
        n_bus.ok    = i_request && (n_bus.sum != '0);
        n_bus.rem_r = NUM_W'(i_red) * SHARE_SCALE;
        n_bus.rem_g = NUM_W'(i_green) * SHARE_SCALE;
        n_bus.rem_b = NUM_W'(i_blue) * SHARE_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_bus <= n_bus;
        end
    end

    `RSW_ASSERT_IMPLY(a_zero_sum_no_ok, i_clk, i_rst_n, r_valid && (r_bus.sum == '0), !r_bus.ok, "zero sum marked for classification")

endmodule

`default_nettype wire

// ----- hdl/rsw_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_share_window_classifier_assert.svh"

module rsw_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire rsw_pkg::t_div_bus i_bus,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output rsw_pkg::t_div_bus     o_bus
);
    import rsw_pkg::*;

    logic             r_valid;
    t_div_bus         r_bus;
    t_div_bus         n_bus;
    logic [DIV_W-1:0] dsh;
    logic [DIV_W-1:0] w_dsh_out;
    logic             w_rem_ok;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_bus   = r_bus;

    always_comb begin
        dsh   = DIV_W'(i_bus.sum) << SHIFT;
        n_bus = i_bus;
        if (DIV_W'(i_bus.rem_r) >= dsh) begin
            n_bus.rem_r      = NUM_W'(DIV_W'(i_bus.rem_r) - dsh);
            n_bus.q_r[SHIFT] = 1'b1;
        end
        if (DIV_W'(i_bus.rem_g) >= dsh) begin
            n_bus.rem_g      = NUM_W'(DIV_W'(i_bus.rem_g) - dsh);
            n_bus.q_g[SHIFT] = 1'b1;
        end
        if (DIV_W'(i_bus.rem_b) >= dsh) begin
            n_bus.rem_b      = NUM_W'(DIV_W'(i_bus.rem_b) - dsh);
            n_bus.q_b[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_bus <= n_bus;
        end
    end

    assign w_dsh_out = DIV_W'(r_bus.sum) << SHIFT;
    assign w_rem_ok  = (DIV_W'(r_bus.rem_r) < w_dsh_out) && (DIV_W'(r_bus.rem_g) < w_dsh_out) &&
                       (DIV_W'(r_bus.rem_b) < w_dsh_out);

    `RSW_ASSERT_IMPLY(a_rem_bound, i_clk, i_rst_n, r_valid && r_bus.ok, w_rem_ok, "remainder too big")

endmodule

`default_nettype wire

// ----- hdl/rsw_class.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_share_window_classifier_assert.svh"

module rsw_class #(
    parameter int CLASS_COUNT = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rsw_pkg::t_window            i_window [CLASS_COUNT],
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire rsw_pkg::t_div_bus           i_bus,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rsw_pkg::CLASS_W-1:0]      o_color_class
);
    import rsw_pkg::*;

    logic               r_valid;
    logic [CLASS_W-1:0] r_class;
    logic [CLASS_W-1:0] n_class;

    assign o_ready       = !r_valid || i_ready;
    assign o_valid       = r_valid;
    assign o_color_class = r_class;

    // The first matching window wins, so the scan runs from the last window down.
    always_comb begin
        n_class = CLASS_NONE;
        if (i_bus.ok) begin
            for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
                if (in_band(i_bus.q_r, i_window[i][47:40], i_window[i][39:32]) &&
                    in_band(i_bus.q_g, i_window[i][31:24], i_window[i][23:16]) &&
                    in_band(i_bus.q_b, i_window[i][15:8], i_window[i][7:0])) begin
                    n_class = CLASS_W'(i + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_class <= n_class;
        end
    end

    `RSW_ASSERT_IMPLY(a_class_range, i_clk, i_rst_n, r_valid, r_class <= CLASS_W'(CLASS_COUNT), "class beyond window count")
    `RSW_ASSERT_NEXT(a_no_ok_no_class, i_clk, i_rst_n, i_valid && o_ready && !i_bus.ok, r_class == CLASS_NONE, "unrequested item got a class")
    `RSW_ASSERT(a_match_needs_ok, i_clk, i_rst_n, !(i_valid && !i_bus.ok && (n_class != CLASS_NONE)), "class found without a valid share")

endmodule

`default_nettype wire

// ----- hdl/rgb_share_window_classifier.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Classifies a red, green and blue reading by each channel's share of the sum,
// floor(100 * x / (R + G + B)), against up to eight share windows tested in order; the
// first match gives class 1 to 8, and no match, a clear request or a zero sum gives 0.
// It takes one transaction per cycle unless the output stalls; a front register forms
// the sum and the scaled counts, a chain of seven divider cells finds one share bit
// each, and a class stage compares windows into the output register. A stalled output
// backs up stage by stage, and empty stages keep accepting. Window registers are to be
// written through the configuration port while no transaction is in flight (unenforced).

module rgb_share_window_classifier #(
    parameter int CLASS_COUNT = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rsw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rsw_pkg::WIN_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Fields from bit 0: red_level[15:0], green_level[15:0], blue_level[15:0].
    input  wire logic [rsw_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,
    // Fields from bit 0: request.
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // Fields from bit 0: color_class[3:0], then zero padding.
    output logic [rsw_pkg::TDATA_OUT_W-1:0]        o_m_axis_tdata
);
    import rsw_pkg::*;

    t_window            r_window [CLASS_COUNT];
    t_div_bus           w_bus    [QBITS+1];
    logic               w_valid  [QBITS+1];
    logic               w_ready  [QBITS+1];
    logic [CLASS_W-1:0] w_class;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CLASS_COUNT; i++) begin
            if (!i_rst_n) begin
                r_window[i] <= WINDOW_RESET[i];
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(i))) begin
                r_window[i] <= i_cfg_wdata;
            end
        end
    end

    rsw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_red     (i_s_axis_tdata[15:0]),
        .i_green   (i_s_axis_tdata[31:16]),
        .i_blue    (i_s_axis_tdata[47:32]),
        .i_request (i_s_axis_tuser),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_bus     (w_bus[0])
    );

    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        rsw_div_cell #(
            .SHIFT (QBITS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_bus   (w_bus[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_bus   (w_bus[k+1])
        );
    end

    rsw_class #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_class (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window      (r_window),
        .i_valid       (w_valid[QBITS]),
        .o_ready       (w_ready[QBITS]),
        .i_bus         (w_bus[QBITS]),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_color_class (w_class)
    );

    assign o_m_axis_tdata = TDATA_OUT_W'(w_class);

endmodule

`default_nettype wire

// ----- test/rgb_share_window_classifier_checker.sv -----
`timescale 1ns / 1ps

module rgb_share_window_classifier_checker #(
    parameter int CLASS_COUNT = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rsw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rsw_pkg::WIN_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    // Fields from bit 0: red_level[15:0], green_level[15:0], blue_level[15:0].
    input  wire logic [rsw_pkg::TDATA_IN_W-1:0]    i_s_tdata,
    // Fields from bit 0: request.
    input  wire logic                              i_s_tuser,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    // Fields from bit 0: color_class[3:0], then zero padding.
    input  wire logic [rsw_pkg::TDATA_OUT_W-1:0]   i_m_tdata,
    output int                                     o_fail_count,
    output int                                     o_classes_pending
);

    localparam int WINDOWS_TESTED = (CLASS_COUNT > 8) ? 8 : CLASS_COUNT;

    localparam logic [47:0] POWER_ON_BOUNDS [8] = '{
        48'd81690446531855, 48'd39746318046230, 48'd33123360579875,
        48'd55199425106195, 48'd52991778231575, 48'd65133549719570,
        48'd36434847734300, 48'd47472812627480
    };

    logic [47:0] share_bounds [8];
    logic [3:0]  class_fifo [$];
    int          fail_tally = 0;

    function automatic logic [6:0] percent_of(input logic [15:0] part,
                                               input logic [17:0] total);
        logic [23:0] scaled;
        scaled = 24'(part) * 24'd100;
        return 7'(scaled / 24'(total));
    endfunction

    function automatic logic share_fits(input logic [6:0] share, input logic [7:0] lo_bound,
                                        input logic [7:0] hi_bound);
        return (lo_bound <= {1'b0, share}) && ({1'b0, share} <= hi_bound);
    endfunction

    function automatic logic [3:0] predict_class(input logic [47:0] levels,
                                                 input logic asked);
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [17:0] total;
        logic [6:0]  red_pct;
        logic [6:0]  green_pct;
        logic [6:0]  blue_pct;
        logic [47:0] bounds;
        logic [3:0]  verdict;
        red     = levels[15:0];
        green   = levels[31:16];
        blue    = levels[47:32];
        total   = 18'(red) + 18'(green) + 18'(blue);
        verdict = rsw_pkg::CLASS_NONE;
        if (asked && total != 18'd0) begin
            red_pct   = percent_of(red, total);
            green_pct = percent_of(green, total);
            blue_pct  = percent_of(blue, total);
            // Scanning from the last window down leaves the first match standing.
            for (int k = WINDOWS_TESTED - 1; k >= 0; k--) begin
                bounds = share_bounds[k];
                if (share_fits(red_pct, bounds[47:40], bounds[39:32]) &&
                    share_fits(green_pct, bounds[31:24], bounds[23:16]) &&
                    share_fits(blue_pct, bounds[15:8], bounds[7:0])) begin
                    verdict = 4'(k + 1);
                end
            end
        end
        return verdict;
    endfunction

    always @(posedge i_clk) begin
        logic [3:0] wanted;
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                share_bounds[k] = POWER_ON_BOUNDS[k];
            end
            class_fifo.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (class_fifo.size() == 0) begin
                    $display("%0t: result 0x%0h arrived with no transaction outstanding",
                             $time, i_m_tdata);
                    fail_tally++;
                end else begin
                    wanted = class_fifo.pop_front();
                    if (i_m_tdata !== {4'b0000, wanted}) begin
                        $display("%0t: color_class mismatch, expected 0x%0h, actual 0x%0h",
                                 $time, {4'b0000, wanted}, i_m_tdata);
                        fail_tally++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                class_fifo.push_back(predict_class(i_s_tdata, i_s_tuser));
            end
            if (i_cfg_we) begin
                share_bounds[i_cfg_idx] = i_cfg_wdata;
            end
        end
        o_fail_count      <= fail_tally;
        o_classes_pending <= class_fifo.size();
    end

endmodule

// ----- test/rgb_share_window_classifier_tb.sv -----
`timescale 1ns / 1ps

module rgb_share_window_classifier_tb;

    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic        request;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_sensor_item;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_CHOKED, SINK_PULSED} t_sink_mode;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [rsw_pkg::CFG_IDX_W-1:0]       cfg_idx   = '0;
    logic [rsw_pkg::WIN_W-1:0]           cfg_wdata = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [rsw_pkg::TDATA_IN_W-1:0]      s_tdata   = '0;
    logic                                s_tuser   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [rsw_pkg::TDATA_OUT_W-1:0]     m_tdata;
    int                                  fail_count;
    int                                  classes_pending;

    rsw_pkg::t_window windows_in_use [rsw_pkg::MAX_CLASSES];
    rsw_pkg::t_window window_plan [rsw_pkg::MAX_CLASSES];
    int               burst_left   = 0;
    int               holds_asked  = 0;
    int               holds_served = 0;

    always #4 clk = ~clk;

    rgb_share_window_classifier i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    rgb_share_window_classifier_checker i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .o_fail_count      (fail_count),
        .o_classes_pending (classes_pending)
    );

    function automatic t_sensor_item reading(input int red, input int green, input int blue,
                                             input bit asked);
        t_sensor_item it;
        it.red     = 16'(red);
        it.green   = 16'(green);
        it.blue    = 16'(blue);
        it.request = asked;
        return it;
    endfunction

    function automatic int aim_share(input logic [7:0] lo_bound, input logic [7:0] hi_bound);
        int top;
        if (lo_bound > hi_bound || lo_bound > 8'd100) begin
            return $urandom_range(0, 100);
        end
        top = (hi_bound > 8'd100) ? 100 : int'(hi_bound);
        return $urandom_range(int'(lo_bound), top);
    endfunction

    function automatic int edge_level();
        int roll;
        roll = $urandom_range(0, 4);
        if (roll == 0) begin
            return 0;
        end else if (roll == 1) begin
            return 1;
        end else if (roll == 2) begin
            return 65534;
        end else if (roll == 3) begin
            return 65535;
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic rsw_pkg::t_window rand_window();
        rsw_pkg::t_window w;
        logic [7:0]       lo_bound;
        logic [7:0]       hi_bound;
        int               roll;
        w = '0;
        for (int c = 0; c < 3; c++) begin
            roll = $urandom_range(0, 9);
            lo_bound = 8'($urandom_range(0, 95));
            if (roll == 0) begin
                lo_bound = 8'($urandom_range(6, 100));
                hi_bound = lo_bound - 8'($urandom_range(1, 6));
            end else if (roll == 1) begin
                hi_bound = 8'($urandom_range(101, 255));
            end else begin
                hi_bound = lo_bound + 8'($urandom_range(0, 12));
            end
            w = {w[31:0], lo_bound, hi_bound};
        end
        return w;
    endfunction

    // Mostly readings aimed into one of the active windows, some with a small
    // offset so the shares land on a band edge; the rest is noise and corner levels.
    function automatic t_sensor_item make_random_item();
        rsw_pkg::t_window w;
        int roll;
        int red_pct;
        int green_pct;
        int blue_pct;
        int peak;
        int scale;
        bit jitter;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            w = windows_in_use[$urandom_range(0, rsw_pkg::MAX_CLASSES - 1)];
            red_pct   = aim_share(w[47:40], w[39:32]);
            green_pct = aim_share(w[31:24], w[23:16]);
            if (red_pct + green_pct <= 100) begin
                blue_pct = 100 - red_pct - green_pct;
            end else begin
                blue_pct = aim_share(w[15:8], w[7:0]);
            end
            peak = red_pct;
            if (green_pct > peak) peak = green_pct;
            if (blue_pct > peak) peak = blue_pct;
            scale  = $urandom_range(1, 65535 / (peak + 1));
            jitter = ($urandom_range(0, 1) == 1);
            return reading(red_pct * scale + (jitter ? $urandom_range(0, scale - 1) : 0),
                           green_pct * scale + (jitter ? $urandom_range(0, scale - 1) : 0),
                           blue_pct * scale + (jitter ? $urandom_range(0, scale - 1) : 0),
                           $urandom_range(0, 19) != 0);
        end else if (roll < 75) begin
            return reading($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), 1'b1);
        end else if (roll < 85) begin
            return reading($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                           1'b1);
        end else if (roll < 92) begin
            return reading(edge_level(), edge_level(), edge_level(),
                           $urandom_range(0, 3) != 0);
        end
        return reading($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), 1'b0);
    endfunction

    task automatic offer_item(input t_sensor_item it);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.blue, it.green, it.red};
        s_tuser  <= it.request;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 19) == 0) gap = 30;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (classes_pending != 0);
    endtask

    task automatic load_windows();
        for (int k = 0; k < rsw_pkg::MAX_CLASSES; k++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= rsw_pkg::CFG_IDX_W'(k);
            cfg_wdata <= window_plan[k];
            windows_in_use[k] = window_plan[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count, input int hold_at, input int drain_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) holds_asked++;
            if (n == drain_at) drain_results();
            offer_item(make_random_item());
        end
    endtask

    task automatic next_phase();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : result_sink
        t_sink_mode mode;
        int         span;
        span = 0;
        mode = SINK_OPEN;
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end else begin
                if (span == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    span = $urandom_range(8, 64);
                end
                span--;
                case (mode)
                    SINK_OPEN: begin
                        m_tready <= 1'b1;
                    end
                    SINK_COIN: begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                    end
                    SINK_CHOKED: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_tready <= (span % 4) != 0;
                    end
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** rgb_share_window_classifier: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_sensor_item opening [$];
        for (int k = 0; k < rsw_pkg::MAX_CLASSES; k++) begin
            windows_in_use[k] = rsw_pkg::WINDOW_RESET[k];
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        opening.push_back(reading(0, 0, 0, 1'b1));
        opening.push_back(reading(0, 0, 0, 1'b0));
        opening.push_back(reading(75, 11, 14, 1'b1));
        opening.push_back(reading(37, 42, 21, 1'b1));
        opening.push_back(reading(31, 35, 34, 1'b1));
        opening.push_back(reading(51, 31, 18, 1'b1));
        opening.push_back(reading(49, 29, 22, 1'b1));
        opening.push_back(reading(60, 23, 17, 1'b1));
        opening.push_back(reading(34, 39, 27, 1'b1));
        opening.push_back(reading(44, 33, 23, 1'b1));
        opening.push_back(reading(75 * 655, 11 * 655, 14 * 655, 1'b0));
        opening.push_back(reading(37 * 600, 42 * 600, 21 * 600, 1'b1));
        opening.push_back(reading(65535, 65535, 65535, 1'b1));
        opening.push_back(reading(65535, 65535, 65535, 1'b0));
        opening.push_back(reading(65535, 0, 0, 1'b1));
        opening.push_back(reading(0, 65535, 0, 1'b1));
        opening.push_back(reading(0, 0, 65535, 1'b1));
        opening.push_back(reading(1, 0, 0, 1'b1));
        opening.push_back(reading(1, 1, 1, 1'b1));
        opening.push_back(reading(73, 12, 15, 1'b1));
        opening.push_back(reading(77, 10, 13, 1'b1));
        opening.push_back(reading(76, 10, 14, 1'b1));
        foreach (opening[k]) begin
            offer_item(opening[k]);
        end
        run_random(250, -1, -1);

        next_phase();
        foreach (window_plan[k]) window_plan[k] = rand_window();
        load_windows();
        run_random(250, 120, -1);

        // All-zero, all-ones (empty), inverted and full-range bands.
        next_phase();
        foreach (window_plan[k]) window_plan[k] = rand_window();
        window_plan[0] = 48'h0000_0000_0000;
        window_plan[1] = 48'hFFFF_FFFF_FFFF;
        window_plan[2] = 48'h4030_4030_4030;
        window_plan[3] = 48'h0064_0064_0064;
        load_windows();
        run_random(250, -1, 100);

        next_phase();
        foreach (window_plan[k]) window_plan[k] = rand_window();
        window_plan[0] = 48'hFFFF_FFFF_FFFF;
        window_plan[7] = 48'h00FF_00FF_00FF;
        load_windows();
        run_random(250, 60, 200);

        next_phase();
        foreach (window_plan[k]) begin
            window_plan[k] = {16'($urandom()), 32'($urandom())};
        end
        load_windows();
        run_random(250, -1, -1);

        next_phase();
        foreach (window_plan[k]) window_plan[k] = rand_window();
        load_windows();
        run_random(300, 150, -1);

        next_phase();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && classes_pending == 0) begin
            $display("** rgb_share_window_classifier: PASSED **");
        end else begin
            $display("** rgb_share_window_classifier: FAILED **");
        end
        $finish;
    end

endmodule
